/* src/polynomial_eval_integrate_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial evaluate/integrate core
// Shorthand for clocked implications with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_EVAL_INTEGRATE_CORE_MACROS_SVH
`define POLYNOMIAL_EVAL_INTEGRATE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PEI_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PEI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pei_pkg.sv */
// ----------------------------------------------------------------------------
// pei_pkg
// Shared widths, codes, types and helper functions of the polynomial core.
// ----------------------------------------------------------------------------
package pei_pkg;

  localparam int DEGREE     = 3;
  localparam int N_CELLS    = DEGREE + 1;
  localparam int DATA_W     = 32;
  localparam int MUL_W      = 2 * DATA_W + 1;
  localparam int Q_W        = DATA_W + 1;
  localparam int COEF_IDX_W = (N_CELLS > 1) ? $clog2(N_CELLS) : 1;
  localparam int CFG_IDX_W  = 3;
  // Each integral term stays below 2^47 in magnitude.
  localparam int SUM_W      = 48 + COEF_IDX_W;

  localparam logic signed [MUL_W-1:0] HALF_Q16 = MUL_W'(32'sd32768);
  localparam logic signed [MUL_W-1:0] HALF_Q30 = MUL_W'(32'sd536870912);

  localparam logic ACT_EVAL  = 1'b0;
  localparam logic ACT_INTEG = 1'b1;

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     ov;
  } sat_t;

  // Data handed from one cell to the next.
  typedef struct packed {
    logic                     valid;
    logic                     action;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] pa;
    logic signed [DATA_W-1:0] pb;
    logic signed [SUM_W-1:0]  sum;
    logic                     ov;
  } cell_bus_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sd2147483647) begin
      r.val = 32'sh7fffffff;
      r.ov  = 1'b1;
    end else if (v < -64'sd2147483648) begin
      r.val = 32'sh80000000;
      r.ov  = 1'b1;
    end else begin
      r.val = v[DATA_W-1:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

  // round(2^30 / (k + 1))
  function automatic logic signed [DATA_W-1:0] recip_q30(input logic [2:0] k);
    logic signed [DATA_W-1:0] r;
    unique case (k)
      3'd0: r = 32'sd1073741824;
      3'd1: r = 32'sd536870912;
      3'd2: r = 32'sd357913941;
      3'd3: r = 32'sd268435456;
      3'd4: r = 32'sd214748365;
      3'd5: r = 32'sd178956971;
      3'd6: r = 32'sd153391689;
      3'd7: r = 32'sd134217728;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

/* src/pei_in_if.sv */
// ----------------------------------------------------------------------------
// pei_in_if
// Request channel: action code and the two Q16.16 points.
// ----------------------------------------------------------------------------
interface pei_in_if import pei_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] point_a;
  logic signed [DATA_W-1:0] point_b;

  modport source (output valid, output action, output point_a, output point_b,
                  input ready);
  modport sink   (input valid, input action, input point_a, input point_b,
                  output ready);
endinterface

/* src/pei_out_if.sv */
// ----------------------------------------------------------------------------
// pei_out_if
// Result channel: saturated Q16.16 value and its overflow flag.
// ----------------------------------------------------------------------------
interface pei_out_if import pei_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

/* src/pei_cell.sv */
// ----------------------------------------------------------------------------
// pei_cell
// One Horner step or one integral term, in four register stages.
// ----------------------------------------------------------------------------
module pei_cell import pei_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] coef_eval,
  input  logic signed [DATA_W-1:0] coef_int,
  input  logic signed [DATA_W-1:0] recip,
  input  logic                     last,
  input  cell_bus_t                bus_i,
  output cell_bus_t                bus_o
);

  typedef struct packed {
    logic                     valid;
    logic                     action;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [MUL_W-1:0]  m1;
    logic signed [MUL_W-1:0]  m2;
    logic signed [MUL_W-1:0]  m3;
    logic signed [SUM_W-1:0]  sum;
    logic                     ov;
  } s1_t;

  typedef struct packed {
    logic                     valid;
    logic                     action;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] pa;
    logic signed [DATA_W-1:0] pb;
    logic signed [Q_W-1:0]    q;
    logic signed [SUM_W-1:0]  sum;
    logic                     ov;
  } s2_t;

  typedef struct packed {
    logic                     valid;
    logic                     action;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] acc;
    logic signed [DATA_W-1:0] pa;
    logic signed [DATA_W-1:0] pb;
    logic signed [MUL_W-1:0]  m4;
    logic signed [SUM_W-1:0]  sum;
    logic                     ov;
  } s3_t;

  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  s3_t       s3_r, s3_nxt;
  cell_bus_t s4_r, s4_nxt;

  logic signed [Q_W-1:0]    diff;
  logic signed [Q_W-1:0]    op_a;
  logic signed [DATA_W-1:0] op_b;
  logic signed [MUL_W-1:0]  rnd_e, rnd_q, rnd_pa, rnd_pb, rnd_t;
  logic signed [DATA_W+17:0] acc_w;
  sat_t                     sat_acc, sat_pa, sat_pb;
  logic signed [SUM_W-1:0]  term;

  // Stage 1: one shared multiplier for acc*x or (b^(k+1) - a^(k+1))*R, plus the powers.
  always_comb begin
    diff = Q_W'(bus_i.pb) - Q_W'(bus_i.pa);
    op_a = (bus_i.action == ACT_INTEG) ? diff  : Q_W'(bus_i.acc);
    op_b = (bus_i.action == ACT_INTEG) ? recip : bus_i.a;
    s1_nxt.valid  = bus_i.valid;
    s1_nxt.action = bus_i.action;
    s1_nxt.a      = bus_i.a;
    s1_nxt.b      = bus_i.b;
    s1_nxt.m1     = MUL_W'(op_a) * MUL_W'(op_b);
    s1_nxt.m2     = MUL_W'(bus_i.pa) * MUL_W'(bus_i.a);
    s1_nxt.m3     = MUL_W'(bus_i.pb) * MUL_W'(bus_i.b);
    s1_nxt.sum    = bus_i.sum;
    s1_nxt.ov     = bus_i.ov;
  end

  // Stage 2: rounding, coefficient add and saturation.
  always_comb begin
    rnd_e   = s1_r.m1 + HALF_Q16;
    rnd_q   = s1_r.m1 + HALF_Q30;
    rnd_pa  = s1_r.m2 + HALF_Q16;
    rnd_pb  = s1_r.m3 + HALF_Q16;
    acc_w   = (DATA_W + 18)'($signed(rnd_e[MUL_W-1:16])) + (DATA_W + 18)'(coef_eval);
    sat_acc = sat32(64'(acc_w));
    sat_pa  = sat32(64'($signed(rnd_pa[MUL_W-1:16])));
    sat_pb  = sat32(64'($signed(rnd_pb[MUL_W-1:16])));
    s2_nxt.valid  = s1_r.valid;
    s2_nxt.action = s1_r.action;
    s2_nxt.a      = s1_r.a;
    s2_nxt.b      = s1_r.b;
    s2_nxt.acc    = sat_acc.val;
    s2_nxt.pa     = sat_pa.val;
    s2_nxt.pb     = sat_pb.val;
    s2_nxt.q      = $signed(rnd_q[Q_W+29:30]);
    s2_nxt.sum    = s1_r.sum;
    // Power saturation after the last term does not feed the result.
    if (s1_r.action == ACT_INTEG) begin
      s2_nxt.ov = s1_r.ov | (~last & (sat_pa.ov | sat_pb.ov));
    end else begin
      s2_nxt.ov = s1_r.ov | sat_acc.ov;
    end
  end

  // Stage 3: coefficient times the scaled difference.
  always_comb begin
    s3_nxt.valid  = s2_r.valid;
    s3_nxt.action = s2_r.action;
    s3_nxt.a      = s2_r.a;
    s3_nxt.b      = s2_r.b;
    s3_nxt.acc    = s2_r.acc;
    s3_nxt.pa     = s2_r.pa;
    s3_nxt.pb     = s2_r.pb;
    s3_nxt.m4     = MUL_W'(coef_int) * MUL_W'(s2_r.q);
    s3_nxt.sum    = s2_r.sum;
    s3_nxt.ov     = s2_r.ov;
  end

  // Stage 4: accumulate the rounded term exactly.
  always_comb begin
    rnd_t = s3_r.m4 + HALF_Q16;
    term  = SUM_W'($signed(rnd_t[MUL_W-1:16]));
    s4_nxt.valid  = s3_r.valid;
    s4_nxt.action = s3_r.action;
    s4_nxt.a      = s3_r.a;
    s4_nxt.b      = s3_r.b;
    s4_nxt.acc    = s3_r.acc;
    s4_nxt.pa     = s3_r.pa;
    s4_nxt.pb     = s3_r.pb;
    s4_nxt.sum    = (s3_r.action == ACT_INTEG) ? s3_r.sum + term : s3_r.sum;
    s4_nxt.ov     = s3_r.ov;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
      s4_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign bus_o = s4_r;

endmodule

/* src/polynomial_eval_integrate_core.sv */
// ----------------------------------------------------------------------------
// polynomial_eval_integrate_core
// Evaluates a Q16.16 polynomial by Horner's rule or forms its definite
// integral between two points, on a chain of identical arithmetic cells.
//
//   Channel   Dir  Payload                          Transfer when
//   in_ch     in   action, point_a, point_b         valid && ready
//   out_ch    out  value, overflow                  valid && ready
//   cfg_*     in   cfg_index, cfg_data (coef_i)     cfg_we
//
// One item is accepted per cycle while the result register is free or being
// drained; each item passes the four register stages of each cell around
// its multipliers and then the result register.
// Reset clears the coefficients, every stage valid bit and the result valid.
// A stalled result freezes the whole chain, so in_ch.ready drops with it.
// ----------------------------------------------------------------------------
module polynomial_eval_integrate_core import pei_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pei_in_if.sink                in_ch,
  pei_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0]     cfg_data
);

  // Coefficient registers; writes beyond the highest coefficient are dropped.
  logic signed [DATA_W-1:0] coef_r [N_CELLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_CELLS; i++) begin
        coef_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index <= CFG_IDX_W'(DEGREE))) begin
      coef_r[cfg_index[COEF_IDX_W-1:0]] <= $signed(cfg_data);
    end
  end

  // Result register contents.
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_ovf_r,   out_ovf_nxt;

  // The chain advances as one: it moves whenever the result register can
  // take whatever leaves the last cell.
  logic en;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  cell_bus_t chain [N_CELLS + 1];

  // The head of the chain starts Horner with a zero accumulator and the
  // integral with the first powers a and b and an empty sum.
  always_comb begin
    chain[0].valid  = in_ch.valid;
    chain[0].action = in_ch.action;
    chain[0].a      = in_ch.point_a;
    chain[0].b      = in_ch.point_b;
    chain[0].acc    = '0;
    chain[0].pa     = in_ch.point_a;
    chain[0].pb     = in_ch.point_b;
    chain[0].sum    = '0;
    chain[0].ov     = 1'b0;
  end

  // Cell j applies coefficient DEGREE-j in Horner order when evaluating and
  // builds the term of coefficient j when integrating.
  for (genvar j = 0; j < N_CELLS; j++) begin : g_cell
    pei_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .coef_eval (coef_r[COEF_IDX_W'(DEGREE - j)]),
      .coef_int  (coef_r[COEF_IDX_W'(j)]),
      .recip     (recip_q30(3'(j))),
      .last      (j == DEGREE),
      .bus_i     (chain[j]),
      .bus_o     (chain[j + 1])
    );
  end

  // Result register: the integral sum is saturated here; an evaluation is
  // already in range after its last Horner step.
  cell_bus_t                fin;
  sat_t                     sat_sum;

  always_comb begin
    fin           = chain[N_CELLS];
    sat_sum       = sat32(64'(fin.sum));
    out_valid_nxt = fin.valid;
    if (fin.action == ACT_INTEG) begin
      out_value_nxt = sat_sum.val;
      out_ovf_nxt   = fin.ov | sat_sum.ov;
    end else begin
      out_value_nxt = fin.acc;
      out_ovf_nxt   = fin.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= out_value_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.overflow = out_ovf_r;

endmodule

/* src/pei_checker.sv */
// ----------------------------------------------------------------------------
// pei_checker
// Port-level checks of the result register and the chain stall.
// ----------------------------------------------------------------------------
`include "polynomial_eval_integrate_core_macros.svh"

module pei_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_overflow
);

  // A result that is not taken stays put.
  `PEI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_value) && $stable(out_overflow),
                   "result changed while stalled")

  // A stalled result stops the chain, so no new request may transfer.
  `PEI_ASSERT_SAME(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready,
                   "request taken during result stall")

  // With the result register empty the chain always moves.
  `PEI_ASSERT_SAME(a_empty_ready, clk, rst_n, !out_valid, in_ready,
                   "not ready with empty result register")

endmodule

bind polynomial_eval_integrate_core pei_checker u_pei_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value),
  .out_overflow (out_ch.overflow)
);

/* tb/polynomial_eval_integrate_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polynomial_eval_integrate_core_tb
// Self-checking bench for the Q16.16 polynomial evaluate/integrate core. A
// predictor inside the bench follows the coefficient writes and works out the
// value and overflow flag of every request, and a checker compares each
// result transfer against the oldest pending prediction. Directed cases cover
// rounding, saturation and the widest bounds. Random phases follow under
// several coefficient profiles, with random gaps on the request side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module polynomial_eval_integrate_core_tb;
  import pei_pkg::*;

  // One predicted result: the saturated value and its overflow flag.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     overflow;
  } poly_result_t;

  // The core's pipeline depth in registers. It sets the pause before a
  // configuration write and the wait at the end of the run.
  localparam int LATENCY = 4 * (DEGREE + 1) + 1;
  localparam int STOP_NS = 2_000_000;
  localparam int MAX_CFG_INDEX = (1 << CFG_IDX_W) - 1;

  localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;
  localparam logic signed [DATA_W-1:0] Q_HALF    = 32'sh0000_8000;
  localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  pei_in_if  in_ch ();
  pei_out_if out_ch ();

  polynomial_eval_integrate_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The bench's own copy of the coefficient registers. They are only
  // rewritten while the core is idle, so a prediction made at the moment a
  // request is accepted always sees the coefficients the core will use.
  logic signed [DATA_W-1:0] coef_model [DEGREE+1];
  poly_result_t             pending_results [$];

  int fail_count    = 0;
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int stall_left    = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Rescale by 2^sh, rounding half an LSB toward plus infinity. The
  // arithmetic shift floors, so this works for negative values as well.
  function automatic longint round_shift(input longint v, input int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Clamp to the signed 32-bit range and latch the overflow flag if needed.
  function automatic longint clamp32(input longint v, inout logic ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic poly_result_t poly_result(input logic act,
                                               input logic signed [DATA_W-1:0] a_in,
                                               input logic signed [DATA_W-1:0] b_in);
    poly_result_t r;
    logic         ov;
    longint       x, acc, pa, pb, d, q, sum, recip;
    ov = 1'b0;
    if (act == ACT_EVAL) begin
      // Horner's rule from the highest coefficient down. Every step
      // saturates on its own, so an early overflow can be pulled back into
      // range by the later steps while the flag stays set.
      x   = longint'(a_in);
      acc = 0;
      for (int i = DEGREE; i >= 0; i--)
        acc = clamp32(round_shift(acc * x, 16) + longint'(coef_model[i]), ov);
      r.value = 32'(acc);
    end else begin
      // Term k is coef_k * (b^(k+1) - a^(k+1)) / (k+1). The power difference
      // is kept to 33 bits, and the division is a multiply by the Q2.30
      // reciprocal round(2^30 / (k+1)). Only the powers and the final sum
      // saturate. The terms are summed exactly.
      pa  = longint'(a_in);
      pb  = longint'(b_in);
      sum = 0;
      for (int i = 0; i <= DEGREE; i++) begin
        recip = ((longint'(1) <<< 30) + (i + 1) / 2) / (i + 1);
        d     = pb - pa;
        q     = round_shift(d * recip, 30);
        sum   = sum + round_shift(longint'(coef_model[i]) * q, 16);
        if (i < DEGREE) begin
          pa = clamp32(round_shift(pa * longint'(a_in), 16), ov);
          pb = clamp32(round_shift(pb * longint'(b_in), 16), ov);
        end
      end
      r.value = 32'(clamp32(sum, ov));
    end
    r.overflow = ov;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  // Only the first ten failures are printed. Later ones are just counted.
  function automatic void note_failure(input string msg);
    if (fail_count < 10)
      $display("ERROR: %s", msg);
    fail_count++;
  endfunction

  // Every result transfer is matched against the oldest pending prediction.
  // The values are sampled at the edge, before any nonblocking update.
  always @(posedge clk) begin : check_results
    poly_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with none pending: value=%h overflow=%b",
                               out_ch.value, out_ch.overflow));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value !== want.value || out_ch.overflow !== want.overflow)
          note_failure($sformatf("expected value=%h overflow=%b, got value=%h overflow=%b",
                                 want.value, want.overflow,
                                 out_ch.value, out_ch.overflow));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Gap or stall length: mostly from the shortest of three ranges, and now and
  // then long enough to back up the whole pipeline.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75)
      return $urandom_range(1, 3);
    if (r < 95)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The result side stalls at random, holding ready low for a length from
  // pick_gap. Setting out_stall_pct to zero gives stretches with no stall.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left = pick_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Points are biased toward small magnitudes, where the results stay in
  // range and the rounding shows. Full-width values still make every bit
  // of every field toggle.
  function automatic logic signed [DATA_W-1:0] pick_point();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      4, 5:       return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      6, 7:       return $urandom();
      8: begin
        case ($urandom_range(0, 6))
          0:       return '0;
          1:       return Q_ONE;
          2:       return Q_NEG_ONE;
          3:       return Q_MAX;
          4:       return Q_MIN;
          5:       return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default:    return 32'(int'($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  // Coefficient profiles: 0 small (within +/-4.0), 1 the same mix as the
  // points, 2 full-width random, 3 only extremes, zero and unit values.
  function automatic logic signed [DATA_W-1:0] pick_coef(input int profile);
    case (profile)
      0: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      1: return pick_point();
      2: return $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return Q_ONE;
          default: return Q_NEG_ONE;
        endcase
      end
    endcase
  endfunction

  // Send one request. It is called at a rising edge and returns at the edge
  // where the transfer happened. If there is no gap, valid stays high from
  // the previous request and only the payload changes.
  task automatic send_request(input logic act,
                              input logic signed [DATA_W-1:0] a,
                              input logic signed [DATA_W-1:0] b);
    int gap;
    gap = ($urandom_range(0, 99) < in_gap_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.point_a <= a;
    in_ch.point_b <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(poly_result(act, a, b));
  endtask

  // Drop valid and wait until every pending result has come back. Then let
  // the pipeline settle before anything touches the coefficients.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Write all coefficients, then one index above DEGREE with random data.
  // The core must ignore that last write, so the model ignores it as well.
  task automatic program_coefs(input logic signed [DATA_W-1:0] c0,
                               input logic signed [DATA_W-1:0] c1,
                               input logic signed [DATA_W-1:0] c2,
                               input logic signed [DATA_W-1:0] c3);
    logic signed [DATA_W-1:0] vals [DEGREE+1];
    vals[0] = c0;
    vals[1] = c1;
    vals[2] = c2;
    vals[3] = c3;
    for (int i = 0; i <= DEGREE + 1; i++) begin
      cfg_we <= 1'b1;
      if (i <= DEGREE) begin
        cfg_index     <= CFG_IDX_W'(i);
        cfg_data      <= vals[i];
        coef_model[i]  = vals[i];
      end else begin
        cfg_index <= CFG_IDX_W'($urandom_range(DEGREE + 1, MAX_CFG_INDEX));
        cfg_data  <= $urandom();
      end
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With the coefficients still at reset, every value is zero. The widest
  // integral still saturates its powers, so its overflow flag is set.
  task automatic test_reset_coefficients();
    send_request(ACT_EVAL, Q_MAX, $urandom());
    send_request(ACT_INTEG, Q_MIN, Q_MAX);
    send_request(ACT_EVAL, pick_point(), pick_point());
    wait_idle();
  endtask

  // Evaluation at zero, at unit and fractional points, at the smallest
  // steps, and at both extremes, where the later Horner steps saturate.
  task automatic test_evaluate();
    program_coefs(Q_ONE, -32'sh0002_0000, Q_HALF, 32'sh0000_4000);
    send_request(ACT_EVAL, '0, $urandom());
    send_request(ACT_EVAL, Q_ONE, $urandom());
    send_request(ACT_EVAL, Q_NEG_ONE, $urandom());
    send_request(ACT_EVAL, Q_HALF, $urandom());
    send_request(ACT_EVAL, 32'sd1, $urandom());
    send_request(ACT_EVAL, -32'sd1, $urandom());
    send_request(ACT_EVAL, 32'sh0003_0000, $urandom());
    send_request(ACT_EVAL, Q_MAX, $urandom());
    send_request(ACT_EVAL, Q_MIN, $urandom());
    wait_idle();
  endtask

  // With one LSB as the cubic coefficient, x = +0.5 and x = -0.5 make an
  // exact half LSB. The first rounds up and the second rounds up to zero.
  task automatic test_rounding();
    program_coefs('0, '0, '0, 32'sd1);
    send_request(ACT_EVAL, Q_HALF, $urandom());
    send_request(ACT_EVAL, -Q_HALF, $urandom());
    wait_idle();
  endtask

  // Integrals over an empty interval, in both directions, and across zero.
  // The two widest bounds give a 33-bit difference and saturated powers.
  task automatic test_integrate();
    program_coefs(Q_ONE, -32'sh0002_0000, Q_HALF, 32'sh0000_4000);
    send_request(ACT_INTEG, Q_ONE, Q_ONE);
    send_request(ACT_INTEG, '0, Q_ONE);
    send_request(ACT_INTEG, Q_ONE, '0);
    send_request(ACT_INTEG, -32'sh0002_0000, 32'sh0003_0000);
    send_request(ACT_INTEG, Q_MIN, Q_MAX);
    send_request(ACT_INTEG, Q_MAX, Q_MIN);
    send_request(ACT_INTEG, -32'sh0008_0000, 32'sh0008_0000);
    wait_idle();
  endtask

  // The final sum saturates in both directions while every power stays in
  // range. Then all coefficients sit at one extreme for evaluation.
  task automatic test_saturation();
    program_coefs(Q_MAX, '0, '0, '0);
    send_request(ACT_INTEG, -32'sh0008_0000, 32'sh0008_0000);
    send_request(ACT_INTEG, 32'sh0008_0000, -32'sh0008_0000);
    wait_idle();
    program_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_request(ACT_EVAL, Q_ONE, $urandom());
    wait_idle();
    program_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_request(ACT_EVAL, Q_MAX, $urandom());
    wait_idle();
  endtask

  // Random requests in eight phases, each with fresh coefficients from a
  // rotating profile. Phase 0 runs without any idling, so the core has to
  // take one request per cycle. Phase 5 stalls the result side hard.
  task automatic test_random_stream();
    for (int phase = 0; phase < 8; phase++) begin
      program_coefs(pick_coef(phase % 4), pick_coef(phase % 4),
                    pick_coef(phase % 4), pick_coef(phase % 4));
      case (phase)
        0: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
        5: begin
          in_gap_pct    = 10;
          out_stall_pct = 60;
        end
        default: begin
          in_gap_pct    = 25;
          out_stall_pct = 25;
        end
      endcase
      repeat (200) send_request(logic'($urandom_range(0, 1)), pick_point(), pick_point());
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  // The result-side ready comes only from the stall process above; it is
  // settled from the first clock edge, well inside reset.
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_EVAL;
    in_ch.point_a <= '0;
    in_ch.point_b <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    for (int i = 0; i <= DEGREE; i++)
      coef_model[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs with moderate idling on both sides.
    in_gap_pct    = 20;
    out_stall_pct = 20;
    test_reset_coefficients();
    test_evaluate();
    test_rounding();
    test_integrate();
    test_saturation();
    test_random_stream();

    // Every test has already drained. Wait a little longer so that a stray
    // extra result would still be caught by the checker.
    repeat (2 * LATENCY) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(STOP_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
